@@ sv/gda_pkg.sv @@
// Shared constants, types and month table for the Gregorian date adder.
`timescale 1ns / 1ps
`default_nettype none
package gda_pkg;

	localparam int DAYS_400Y = 146097;
	localparam int DAYS_100Y = 36524;
	localparam int DAYS_4Y   = 1461;
	localparam int DAYS_1Y   = 365;

	localparam int RECIP_100    = 5243;
	localparam int RECIP_100_SH = 19;
	localparam int RECIP_400Y   = 14699;
	localparam int RECIP_4Y     = 1435;

	localparam int NUM_W = 25;

	typedef struct packed {
		logic                    vld;
		logic signed [NUM_W-1:0] num;
	} dnum_t;

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + {8'd0, (leap && (m > 4'd2))};
	endfunction

endpackage
`default_nettype wire

@@ sv/gda_fwd.sv @@
// Date to day number: three stages from day, month, year and offset to a signed count.
`timescale 1ns / 1ps
`default_nettype none
module gda_fwd
	import gda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic [4:0]         day,
	input  wire logic [3:0]         month,
	input  wire logic [13:0]        year,
	input  wire logic signed [22:0] offset,
	output dnum_t                   dnum
);

	logic               vld_s1, vld_s2, vld_s3;
	logic [4:0]         day_s1, day_s2;
	logic [3:0]         month_s1, month_s2;
	logic [13:0]        year_s1;
	logic signed [22:0] offset_s1, offset_s2;
	logic [26:0]        p100_s1;
	logic [22:0]        dby_s2;
	logic               leap_s2;
	logic signed [NUM_W-1:0] num_s3;

	logic [3:0]  month_c;
	logic [7:0]  q100;
	logic [14:0] hund;
	logic        div100, div400, leap_c;
	logic [12:0] ceil4;
	logic [8:0]  ceil100;
	logic [6:0]  ceil400;
	logic [22:0] dby_c;
	logic signed [NUM_W-1:0] num_c;

	always_comb begin
		if (month == 4'd0) begin
			month_c = 4'd1;
		end else if (month > 4'd12) begin
			month_c = 4'd12;
		end else begin
			month_c = month;
		end
	end

	always_comb begin
		q100    = p100_s1[RECIP_100_SH+7:RECIP_100_SH];
		hund    = 15'(q100) * 15'(100);
		div100  = (hund == {1'b0, year_s1});
		div400  = div100 && (q100[1:0] == 2'd0);
		leap_c  = ((year_s1[1:0] == 2'd0) && !div100) || div400;
		ceil4   = {1'b0, year_s1[13:2]} + {12'd0, |year_s1[1:0]};
		ceil100 = {1'b0, q100} + {8'd0, !div100};
		ceil400 = {1'b0, q100[7:2]} + {6'd0, !div400};
		dby_c   = 23'(year_s1) * 23'(DAYS_1Y) + {10'd0, ceil4} - {14'd0, ceil100}
			+ {16'd0, ceil400};
	end

	assign num_c = $signed({2'b00, dby_s2}) + $signed({16'd0, month_start(month_s2, leap_s2)})
		+ $signed({20'd0, day_s2}) + $signed({{2{offset_s2[22]}}, offset_s2}) - 25'sd367;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		day_s1    <= day;
		month_s1  <= month_c;
		year_s1   <= year;
		offset_s1 <= offset;
		p100_s1   <= 27'(year) * 27'(RECIP_100);

		day_s2    <= day_s1;
		month_s2  <= month_s1;
		offset_s2 <= offset_s1;
		dby_s2    <= dby_c;
		leap_s2   <= leap_c;

		num_s3    <= num_c;
	end

	assign dnum.vld = vld_s3;
	assign dnum.num = num_s3;

endmodule
`default_nettype wire

@@ sv/gda_bwd.sv @@
// Day number to date: ten stages of reciprocal division, year assembly and month search.
`timescale 1ns / 1ps
`default_nettype none
module gda_bwd
	import gda_pkg::*;
#(
	parameter int YEAR_MAX = 9999
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire dnum_t dnum,
	output logic       vld,
	output logic [4:0] day,
	output logic [3:0] month,
	output logic [13:0] year,
	output logic       in_range
);

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9, neg_s10;

	logic [23:0] nn_s4;
	logic [37:0] pq_s4;
	logic [6:0]  q_s5, q_s6, q_s7, q_s8, q_s9, q_s10;
	logic [18:0] r0_s5;
	logic [17:0] r_s6;
	logic [2:0]  cent_s7, cent_s8, cent_s9, cent_s10;
	logic [15:0] r1_s7, r1_s8;
	logic [26:0] pf_s8;
	logic [4:0]  f_s9, f_s10;
	logic [11:0] r2_s9;
	logic [10:0] r2_s10;
	logic [8:0]  doy_s11, doy_s12;
	logic [14:0] yr_s11, yr_s12;
	logic        leap_s11, leap_s12, ok_s11, ok_s12;
	logic [3:0]  mon_s12;
	logic [4:0]  day_s13;
	logic [3:0]  month_s13;
	logic [13:0] year_s13;
	logic        ok_s13;

	logic [6:0]  qe;
	logic [23:0] r0_w;
	logic [2:0]  cent_w;
	logic [17:0] r1_w;
	logic [4:0]  fe;
	logic [15:0] r2_w;
	logic [2:0]  o_w;
	logic        edge_w, leap_w, ok_w;
	logic [10:0] doy_w;
	logic [8:0]  doy_c;
	logic [14:0] yr_w;
	logic [3:0]  mon_w;
	logic [8:0]  day_w;

	assign qe   = pq_s4[37:31];
	assign r0_w = nn_s4 - 24'(qe) * 24'(DAYS_400Y);

	assign cent_w = {2'b00, r_s6 >= 18'(DAYS_100Y)} + {2'b00, r_s6 >= 18'(2 * DAYS_100Y)}
		+ {2'b00, r_s6 >= 18'(3 * DAYS_100Y)} + {2'b00, r_s6 >= 18'(4 * DAYS_100Y)};
	assign r1_w   = r_s6 - 18'(cent_w) * 18'(DAYS_100Y);

	assign fe   = pf_s8[25:21];
	assign r2_w = r1_s8 - 16'(fe) * 16'(DAYS_4Y);

	always_comb begin
		o_w = {2'b00, r2_s10 >= 11'(DAYS_1Y)} + {2'b00, r2_s10 >= 11'(2 * DAYS_1Y)}
			+ {2'b00, r2_s10 >= 11'(3 * DAYS_1Y)} + {2'b00, r2_s10 >= 11'(4 * DAYS_1Y)};
		doy_w  = r2_s10 - 11'(o_w) * 11'(DAYS_1Y);
		edge_w = (cent_s10 == 3'd4) || (o_w == 3'd4);
		doy_c  = edge_w ? 9'(DAYS_1Y) : doy_w[8:0];
		yr_w   = 15'(q_s10) * 15'(400) + 15'(cent_s10) * 15'(100) + {8'd0, f_s10, 2'b00}
			+ {12'd0, o_w} + {14'd0, !edge_w};
		leap_w = edge_w || ((o_w == 3'd3) && ((f_s10 != 5'd24) || (cent_s10 == 3'd3)));
		ok_w   = !neg_s10 && ({2'b00, yr_w} <= 17'(YEAR_MAX));
	end

	always_comb begin
		mon_w = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (doy_s11 >= month_start(4'(k), leap_s11)) begin
				mon_w = 4'(k);
			end
		end
	end

	assign day_w = doy_s12 - month_start(mon_s12, leap_s12) + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s4  <= dnum.vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		neg_s4 <= dnum.num[NUM_W-1];
		nn_s4  <= dnum.num[NUM_W-2:0];
		pq_s4  <= 38'(dnum.num[NUM_W-2:0]) * 38'(RECIP_400Y);

		neg_s5 <= neg_s4;
		q_s5   <= qe;
		r0_s5  <= r0_w[18:0];

		neg_s6 <= neg_s5;
		if (r0_s5 >= 19'(DAYS_400Y)) begin
			q_s6 <= q_s5 + 7'd1;
			r_s6 <= 18'(r0_s5 - 19'(DAYS_400Y));
		end else begin
			q_s6 <= q_s5;
			r_s6 <= r0_s5[17:0];
		end

		neg_s7  <= neg_s6;
		q_s7    <= q_s6;
		cent_s7 <= cent_w;
		r1_s7   <= r1_w[15:0];

		neg_s8  <= neg_s7;
		q_s8    <= q_s7;
		cent_s8 <= cent_s7;
		r1_s8   <= r1_s7;
		pf_s8   <= 27'(r1_s7) * 27'(RECIP_4Y);

		neg_s9  <= neg_s8;
		q_s9    <= q_s8;
		cent_s9 <= cent_s8;
		f_s9    <= fe;
		r2_s9   <= r2_w[11:0];

		neg_s10  <= neg_s9;
		q_s10    <= q_s9;
		cent_s10 <= cent_s9;
		if (r2_s9 >= 12'(DAYS_4Y)) begin
			f_s10  <= f_s9 + 5'd1;
			r2_s10 <= 11'(r2_s9 - 12'(DAYS_4Y));
		end else begin
			f_s10  <= f_s9;
			r2_s10 <= r2_s9[10:0];
		end

		doy_s11  <= doy_c;
		yr_s11   <= yr_w;
		leap_s11 <= leap_w;
		ok_s11   <= ok_w;

		mon_s12  <= mon_w;
		doy_s12  <= doy_s11;
		yr_s12   <= yr_s11;
		leap_s12 <= leap_s11;
		ok_s12   <= ok_s11;

		day_s13   <= ok_s12 ? day_w[4:0] : 5'd0;
		month_s13 <= ok_s12 ? mon_s12 : 4'd0;
		year_s13  <= ok_s12 ? yr_s12[13:0] : 14'd0;
		ok_s13    <= ok_s12;
	end

	assign vld      = vld_s13;
	assign day      = day_s13;
	assign month    = month_s13;
	assign year     = year_s13;
	assign in_range = ok_s13;

	a_rem400_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && !neg_s6 |-> r_s6 < 18'(DAYS_400Y))
		else $error("remainder of 400-year cycle not reduced");

	a_rem4_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 && !neg_s10 |-> r2_s10 < 11'(DAYS_4Y))
		else $error("remainder of 4-year cycle not reduced");

	a_last_day_leap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s11 && ok_s11 && (doy_s11 == 9'(DAYS_1Y)) |-> leap_s11)
		else $error("day 366 in a common year");

endmodule
`default_nettype wire

@@ sv/gregorian_date_add_days_top.sv @@
// Top level of the Gregorian date adder: command handshake around the date pipeline.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------------
//   command  | start, busy           | start_day, start_month, start_year, day_offset
//   result   | done (one-cycle pulse) | result_day, result_month, result_year, in_range
//
// One item enters per cycle while busy is low; results leave at done in the order the items were taken.
// The pipeline has 13 stages: 3 stages to the day count,
// 10 stages for the reciprocal divisions and the month search.
// busy is high only in the first cycle after reset; the pipeline never stalls.
// Reset clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_add_days_top
	import gda_pkg::*;
#(
	parameter int YEAR_MAX = 9999
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [4:0]         start_day,
	input  wire logic [3:0]         start_month,
	input  wire logic [13:0]        start_year,
	input  wire logic signed [22:0] day_offset,
	output logic                    done,
	output logic [4:0]              result_day,
	output logic [3:0]              result_month,
	output logic [13:0]             result_year,
	output logic                    in_range
);

	logic  busy_q;
	logic  accept;
	dnum_t dnum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	gda_fwd u_fwd (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.day    (start_day),
		.month  (start_month),
		.year   (start_year),
		.offset (day_offset),
		.dnum   (dnum)
	);

	gda_bwd #(
		.YEAR_MAX (YEAR_MAX)
	) u_bwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.dnum     (dnum),
		.vld      (done),
		.day      (result_day),
		.month    (result_month),
		.year     (result_year),
		.in_range (in_range)
	);

	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> (result_day == 5'd0) && (result_month == 4'd0)
			&& (result_year == 14'd0))
		else $error("out-of-range result carries nonzero date");

	a_date_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_range |-> (result_month >= 4'd1) && (result_month <= 4'd12)
			&& (result_day >= 5'd1) && (result_day <= 5'd31))
		else $error("in-range result has illegal day or month");

endmodule
`default_nettype wire

@@ dv/gregorian_date_add_days_top_tb.sv @@
// Self-checking testbench for the Gregorian date adder: directed corners, then random dates.
`timescale 1ns / 1ps
module gregorian_date_add_days_top_tb;
	import gda_pkg::*;

	localparam int YEAR_MAX    = 9999;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 20;
	localparam int NUM_CORNERS = 23;
	localparam int NUM_PHASES  = 4;
	localparam int PHASE_ITEMS = 275;
	localparam int IDLE_PCT [NUM_PHASES] = '{0, 79, 29, 0};
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [4:0]         day;
		logic [3:0]         month;
		logic [13:0]        year;
		logic signed [22:0] offset;
	} date_cmd_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        in_range;
	} date_res_t;

	typedef struct packed {
		date_cmd_t cmd;
		logic      given;
		date_res_t res;
	} corner_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic [4:0]         start_day    = 5'd1;
	logic [3:0]         start_month  = 4'd1;
	logic [13:0]        start_year   = 14'd1;
	logic signed [22:0] day_offset   = 23'sd0;
	logic               busy;
	logic               done;
	logic [4:0]         result_day;
	logic [3:0]         result_month;
	logic [13:0]        result_year;
	logic               in_range;

	date_res_t   pending_dates [$];
	date_res_t   want_date;
	corner_row_t corner_rows [NUM_CORNERS];
	int          err_cnt       = 0;
	int          item_cnt      = 0;
	int          in_range_cnt  = 0;
	int          out_range_cnt = 0;
	int          cycle_cnt     = 0;

	gregorian_date_add_days_top #(
		.YEAR_MAX(YEAR_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.day_offset(day_offset),
		.done(done),
		.result_day(result_day),
		.result_month(result_month),
		.result_year(result_year),
		.in_range(in_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(input longint y, input int m);
		return MONTH_DAYS[m - 1] + ((m == 2 && leap_year(y)) ? 1 : 0);
	endfunction

	function automatic date_res_t shift_date(input date_cmd_t c);
		longint    y_in, n, q, r, cent, quad, yrs, yr, doy, ofs;
		int        mon, m;
		date_res_t res;
		res  = '0;
		y_in = c.year;
		mon  = c.month;
		if (mon < 1) begin
			mon = 1;
		end
		if (mon > 12) begin
			mon = 12;
		end
		ofs = $signed(c.offset);
		n   = y_in * 365 + (y_in + 3) / 4 - (y_in + 99) / 100 + (y_in + 399) / 400;
		for (m = 1; m < mon; m++) begin
			n += month_days(y_in, m);
		end
		n += longint'(c.day) - 1 + ofs - 366;
		if (n < 0) begin
			return res;
		end
		q    = n / DAYS_400Y;
		r    = n % DAYS_400Y;
		cent = r / DAYS_100Y;
		r    = r % DAYS_100Y;
		quad = r / DAYS_4Y;
		r    = r % DAYS_4Y;
		yrs  = r / DAYS_1Y;
		doy  = r % DAYS_1Y;
		yr   = q * 400 + cent * 100 + quad * 4 + yrs;
		// last day of a leap year lands on the fourth full year or century
		if (cent == 4 || yrs == 4) begin
			doy = 365;
		end else begin
			yr += 1;
		end
		if (yr < 1 || yr > YEAR_MAX) begin
			return res;
		end
		m = 1;
		while (m < 12 && doy >= month_days(yr, m)) begin
			doy -= month_days(yr, m);
			m++;
		end
		res.day      = 5'(doy + 1);
		res.month    = 4'(m);
		res.year     = 14'(yr);
		res.in_range = 1'b1;
		return res;
	endfunction

	function automatic date_cmd_t random_date_cmd();
		date_cmd_t c;
		int        ofs;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			c.day    = 5'($urandom);
			c.month  = 4'($urandom);
			c.year   = 14'($urandom);
			c.offset = 23'($urandom);
			return c;
		end
		pick = $urandom_range(9);
		if (pick == 0) begin
			c.year = 14'($urandom_range(3, 1));
		end else if (pick == 1) begin
			c.year = 14'($urandom_range(YEAR_MAX, YEAR_MAX - 2));
		end else begin
			c.year = 14'($urandom_range(YEAR_MAX, 1));
		end
		c.month = 4'($urandom_range(12, 1));
		c.day   = 5'($urandom_range(month_days(c.year, c.month), 1));
		pick    = $urandom_range(2);
		if (pick == 0) begin
			ofs = $urandom_range(800) - 400;
		end else if (pick == 1) begin
			ofs = $urandom_range(120000) - 60000;
		end else begin
			ofs = $urandom;
		end
		c.offset = ofs[22:0];
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
		end
	endtask

	task automatic push_cmd(input date_cmd_t c, input date_res_t want, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		start_day   <= c.day;
		start_month <= c.month;
		start_year  <= c.year;
		day_offset  <= c.offset;
		do
			@(posedge clk);
		while (busy);
		pending_dates.push_back(want);
		item_cnt++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_dates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, pending_dates.size());
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want_date = pending_dates.pop_front();
				check_field("result_day", result_day, want_date.day);
				check_field("result_month", result_month, want_date.month);
				check_field("result_year", result_year, want_date.year);
				check_field("in_range", in_range, want_date.in_range);
				if (want_date.in_range) begin
					in_range_cnt++;
				end else begin
					out_range_cnt++;
				end
			end
		end
	end

	initial begin : stimulus
		date_cmd_t c;
		int        i;
		int        ph;
		corner_rows = '{
			'{'{5'd1, 4'd1, 14'd1, 23'h000000}, 1'b1, '{5'd1, 4'd1, 14'd1, 1'b1}},
			'{'{5'd1, 4'd1, 14'd1, 23'h7FFFFF}, 1'b1, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd31, 4'd12, 14'd9999, 23'h000000}, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b1}},
			'{'{5'd31, 4'd12, 14'd9999, 23'h000001}, 1'b1, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd1, 4'd1, 14'd1, 23'h3FFFFF}, 1'b0, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd31, 4'd12, 14'd9999, 23'h400000}, 1'b0, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd29, 4'd2, 14'd2000, 23'h000000}, 1'b1, '{5'd29, 4'd2, 14'd2000, 1'b1}},
			'{'{5'd1, 4'd3, 14'd1900, 23'h7FFFFF}, 1'b1, '{5'd28, 4'd2, 14'd1900, 1'b1}},
			'{'{5'd0, 4'd3, 14'd2024, 23'h000000}, 1'b1, '{5'd29, 4'd2, 14'd2024, 1'b1}},
			'{'{5'd31, 4'd2, 14'd2023, 23'h000000}, 1'b0, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd15, 4'd0, 14'd2020, 23'h000000}, 1'b1, '{5'd15, 4'd1, 14'd2020, 1'b1}},
			'{'{5'd5, 4'd15, 14'd2020, 23'h000000}, 1'b1, '{5'd5, 4'd12, 14'd2020, 1'b1}},
			'{'{5'd1, 4'd1, 14'd0, 23'd366}, 1'b1, '{5'd1, 4'd1, 14'd1, 1'b1}},
			'{'{5'd1, 4'd1, 14'd0, 23'h000000}, 1'b1, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd31, 4'd15, 14'h3FFF, 23'h3FFFFF}, 1'b1, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd0, 4'd0, 14'h3FFF, 23'h400000}, 1'b0, '{5'd0, 4'd0, 14'd0, 1'b0}},
			'{'{5'd31, 4'd12, 14'd2000, 23'h000000}, 1'b1, '{5'd31, 4'd12, 14'd2000, 1'b1}},
			'{'{5'd31, 4'd12, 14'd2004, 23'h000000}, 1'b1, '{5'd31, 4'd12, 14'd2004, 1'b1}},
			'{'{5'd1, 4'd1, 14'd2001, 23'h7FFFFF}, 1'b1, '{5'd31, 4'd12, 14'd2000, 1'b1}},
			'{'{5'd28, 4'd2, 14'd2100, 23'h000001}, 1'b1, '{5'd1, 4'd3, 14'd2100, 1'b1}},
			'{'{5'd28, 4'd2, 14'd2024, 23'h000001}, 1'b1, '{5'd29, 4'd2, 14'd2024, 1'b1}},
			'{'{5'd31, 4'd12, 14'd9999, 23'h7FFFFF}, 1'b1, '{5'd30, 4'd12, 14'd9999, 1'b1}},
			'{'{5'd0, 4'd0, 14'd0, 23'h000000}, 1'b1, '{5'd0, 4'd0, 14'd0, 1'b0}}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < NUM_CORNERS; i++) begin
			push_cmd(corner_rows[i].cmd,
				corner_rows[i].given ? corner_rows[i].res : shift_date(corner_rows[i].cmd), 0);
		end
		drain();
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			for (i = 0; i < PHASE_ITEMS; i++) begin
				c = random_date_cmd();
				push_cmd(c, shift_date(c), IDLE_PCT[ph]);
			end
			// hold off the next item until the pipeline is empty
			drain();
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_dates.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_dates.size()));
		end
		$display("Covered %0d items over corner dates and %0d idle mixes", item_cnt, NUM_PHASES);
		$display("Dates in range: %0d, out of range: %0d", in_range_cnt, out_range_cnt);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/gda_pkg.sv
sv/gda_fwd.sv
sv/gda_bwd.sv
sv/gregorian_date_add_days_top.sv
dv/gregorian_date_add_days_top_tb.sv
